/* src/lta_pkg.sv */
package lta_pkg;

  // Request kinds carried on the mode field
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PICK  = 1'b1;

  // Fixed field widths of the request and result ports
  localparam int SLOT_IN_W    = 6;
  localparam int TICKET_IN_W  = 8;
  localparam int TICK_W       = 32;
  localparam int WINNER_W     = 6;
  localparam int TOTAL_OUT_W  = 14;

  // Seed scrambling: s ^ (s << A) ^ (s >> R) ^ (s << B) over 64 bits
  localparam int SEED_W       = 64;
  localparam int STEP_W       = $clog2(SEED_W);
  localparam int SCR_SHL_A    = 5;
  localparam int SCR_SHR      = 17;
  localparam int SCR_SHL_B    = 13;

  // Operations of the shared add/subtract unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

/* src/lta_ram.sv */
module lta_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lta_alu.sv */
module lta_alu
  import lta_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] res,
  output logic             borrow
);

  logic [WIDTH-1:0] b_sel;
  logic             cin;
  logic             cout;

  // Invert the second operand for subtraction
  always_comb begin
    unique case (op)
      ALU_ADD: begin
        b_sel = b;
        cin   = 1'b0;
      end
      ALU_SUB: begin
        b_sel = ~b;
        cin   = 1'b1;
      end
      default: begin
        b_sel = b;
        cin   = 1'b0;
      end
    endcase
  end

  // One adder serves accumulate, trial subtract and compare
  assign {cout, res} = {1'b0, a} + {1'b0, b_sel} + {{WIDTH{1'b0}}, cin};
  assign borrow      = (op == ALU_SUB) && !cout;

endmodule

/* src/lottery_ticket_arbiter_core.sv */
// Channel   Handshake            Fields
// request   start / busy         mode, slot, tickets, runnable, tick_count
// result    done (one cycle)     winner_slot, winner_found, ticket_total
//
// A write request raises done in the next cycle.
// A pick holds busy through a sweep of the slot RAM to sum tickets, 64 steps
// of the bit-serial remainder and a second RAM sweep for the walk (shorter
// when the winner comes early), all on one add/subtract unit and one RAM
// read port; a zero ticket total ends the pick after the sum sweep. done is
// high in the first cycle in which busy is low.
// Reset clears the per-slot valid bits, so every slot reads as empty
// straight away; no clearing pass. Results cannot be stalled.
module lottery_ticket_arbiter_core
  import lta_pkg::*;
#(
  parameter int SLOTS       = 64,
  parameter int TICKET_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   mode,
  input  logic [SLOT_IN_W-1:0]   slot,
  input  logic [TICKET_IN_W-1:0] tickets,
  input  logic                   runnable,
  input  logic [TICK_W-1:0]      tick_count,
  output logic                   done,
  output logic [WINNER_W-1:0]    winner_slot,
  output logic                   winner_found,
  output logic [TOTAL_OUT_W-1:0] ticket_total
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int TOTAL_W = $clog2(SLOTS * ((1 << TICKET_BITS) - 1) + 1);
  localparam int AW      = TOTAL_W + 1;
  localparam int ENTRY_W = TICKET_BITS + 1;
  localparam logic [TOTAL_OUT_W-1:0] TOTAL_SAT = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     idx;
  logic                 pend;
  logic                 pend_ok;
  logic [SLOT_W-1:0]    pend_idx;
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W-1:0]   rem;
  logic [SEED_W-1:0]    seed;
  logic [STEP_W-1:0]    step;
  logic [SLOTS-1:0]     valid_q;

  logic                 accept;
  logic                 slot_ok;
  logic                 ram_we;
  logic [SLOT_W-1:0]    waddr;
  logic [SLOT_W-1:0]    raddr;
  logic [ENTRY_W-1:0]   rdata;
  logic [TICKET_BITS-1:0] rd_tickets;
  logic                 rd_run;
  logic                 issue;
  logic                 take;
  logic [AW-1:0]        tk_ext;
  logic [SEED_W-1:0]    seed_in;

  alu_op_t              alu_op;
  logic [AW-1:0]        alu_a;
  logic [AW-1:0]        alu_b;
  logic [AW-1:0]        alu_res;
  logic                 alu_borrow;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = (9'(slot) < 9'(SLOTS));
  assign waddr   = SLOT_W'(slot);
  assign ram_we  = accept && (mode == MODE_WRITE) && slot_ok;
  assign raddr   = idx[SLOT_W-1:0];

  // Scramble the tick into the 64-bit dividend
  assign seed_in = SEED_W'(tick_count) ^ (SEED_W'(tick_count) << SCR_SHL_A)
                 ^ (SEED_W'(tick_count) >> SCR_SHR)
                 ^ (SEED_W'(tick_count) << SCR_SHL_B);

  lta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({runnable, TICKET_BITS'(tickets)}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Drop entries never written or not runnable
  assign rd_tickets = rdata[TICKET_BITS-1:0];
  assign rd_run     = rdata[TICKET_BITS];
  assign issue      = ((state == ST_SUM) || (state == ST_WALK)) && (idx != CNT_W'(SLOTS));
  assign take       = pend && pend_ok && rd_run;
  assign tk_ext     = take ? AW'(rd_tickets) : '0;

  // Steer the shared unit by phase
  always_comb begin
    unique case (state)
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = {rem, seed[SEED_W-1]};
        alu_b  = {1'b0, total};
      end
      ST_WALK: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, rem};
        alu_b  = tk_ext;
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = {1'b0, total};
        alu_b  = tk_ext;
      end
    endcase
  end

  lta_alu #(
    .WIDTH (AW)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // Sequencer: write requests, sum sweep, bit-serial remainder, walk sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      pend         <= 1'b0;
      valid_q      <= '0;
      winner_found <= 1'b0;
    end else begin
      done     <= 1'b0;
      pend     <= issue;
      pend_ok  <= valid_q[raddr];
      pend_idx <= raddr;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (mode == MODE_WRITE) begin
              if (slot_ok) begin
                valid_q[waddr] <= 1'b1;
              end
              done         <= 1'b1;
              winner_slot  <= '0;
              winner_found <= 1'b0;
              ticket_total <= '0;
            end else begin
              seed  <= seed_in;
              total <= '0;
              idx   <= '0;
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          total <= alu_res[TOTAL_W-1:0];
          if (!issue && !pend) begin
            ticket_total <= (32'(total) > 32'(TOTAL_SAT)) ? TOTAL_SAT
                                                           : TOTAL_OUT_W'(total);
            if (total == '0) begin
              done         <= 1'b1;
              winner_slot  <= '0;
              winner_found <= 1'b0;
              state        <= ST_IDLE;
            end else begin
              rem   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // Keep the trial difference when it does not borrow
          rem  <= alu_borrow ? alu_a[TOTAL_W-1:0] : alu_res[TOTAL_W-1:0];
          seed <= seed << 1;
          step <= step + 1'b1;
          if (step == '1) begin
            idx   <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (take && alu_borrow) begin
            done         <= 1'b1;
            winner_slot  <= WINNER_W'(pend_idx);
            winner_found <= 1'b1;
            state        <= ST_IDLE;
          end else if (take) begin
            rem <= alu_res[TOTAL_W-1:0];
          end else if (!issue && !pend) begin
            done         <= 1'b1;
            winner_slot  <= '0;
            winner_found <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_PICK) |=> busy)
    else $error("pick request did not start the sequencer");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_winner_has_total: assert property (@(posedge clk) disable iff (rst)
    done && winner_found |-> (ticket_total != '0))
    else $error("winner reported with zero ticket total");

  a_rem_below_total: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) || (state == ST_WALK) |-> (rem < total))
    else $error("remainder not below ticket total");

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");
`endif

endmodule
